[rtl/foc_ipcp_pkg.sv]
`timescale 1ns / 1ps
package foc_ipcp_pkg;

   localparam int ENCODER_BITS    = 12;
   localparam int SINE_TABLE_BITS = 10;

   localparam int QTR_BITS  = SINE_TABLE_BITS - 2;
   localparam int QTR_DEPTH = 1 << QTR_BITS;

   localparam int Q_BITS         = 16;
   localparam int BITS_PER_STAGE = 2;
   localparam int DIV_STAGES     = Q_BITS / BITS_PER_STAGE;

   localparam int NUM_LANES = 3;
   localparam int MAG_W     = 17;
   localparam int NUM_W     = MAG_W + 16;

   localparam logic [15:0] POLE_PAIRS_RST = 16'd7;
   localparam logic [15:0] VOLT_Q_RST     = 16'd4915;
   localparam logic [MAG_W-1:0] Q15_ONE   = MAG_W'(32768);

   typedef enum logic [1:0] {
      CSR_POLE_PAIRS   = 2'd0,
      CSR_ANGLE_OFFSET = 2'd1,
      CSR_VOLT_D       = 2'd2,
      CSR_VOLT_Q       = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [NUM_LANES-1:0][NUM_W-1:0] num;
      logic [NUM_LANES-1:0][MAG_W-1:0] mag;
      logic [NUM_LANES-1:0]            neg;
      logic [MAG_W-1:0]                m;
      logic                            scaled;
   } div_in_type;

   typedef struct packed {
      logic [NUM_LANES-1:0][Q_BITS-1:0] quo;
      logic [NUM_LANES-1:0][MAG_W-1:0]  mag;
      logic [NUM_LANES-1:0]             neg;
      logic                             scaled;
   } div_out_type;

   typedef logic [15:0] qtab_type [QTR_DEPTH];

   function automatic logic [15:0] quarter_sine(longint x);
      longint x2;
      longint r;
      longint s;
      x2 = (x * x) >>> 15;
      r  = 21167 - ((2611 * x2) >>> 15);
      r  = 51472 - ((x2 * r) >>> 15);
      s  = (x * r) >>> 15;
      if (s > 32767) begin
         s = 32767;
      end
      return 16'(s);
   endfunction

   function automatic qtab_type build_qtab();
      qtab_type t;
      for (int k = 0; k < QTR_DEPTH; k++) begin
         t[k] = quarter_sine(longint'(k) << (17 - SINE_TABLE_BITS));
      end
      return t;
   endfunction

   localparam qtab_type QTAB = build_qtab();

   // quarter-wave table unfolded by quadrant symmetry
   function automatic logic signed [15:0] sine_lookup(logic [SINE_TABLE_BITS-1:0] idx);
      logic [1:0]          quad;
      logic [QTR_BITS-1:0] k;
      logic [15:0]         s;
      quad = idx[SINE_TABLE_BITS-1 -: 2];
      k    = idx[QTR_BITS-1:0];
      if (quad[0]) begin
         if (k == '0) begin
            s = 16'd32767;
         end else begin
            s = QTAB[QTR_BITS'(-k)];
         end
      end else begin
         s = QTAB[k];
      end
      return quad[1] ? -$signed(s) : $signed(s);
   endfunction

endpackage

[rtl/foc_ipcp_divider.sv]
`timescale 1ns / 1ps
module foc_ipcp_divider
   import foc_ipcp_pkg::*;
(
   input  logic                  clock,
   input  logic [DIV_STAGES-1:0] en,
   input  div_in_type            div_in,
   output div_out_type           div_out
);

   typedef struct packed {
      logic [NUM_LANES-1:0][MAG_W-1:0]  rem;
      logic [NUM_LANES-1:0][Q_BITS-1:0] nlo;
      logic [NUM_LANES-1:0][MAG_W-1:0]  mag;
      logic [NUM_LANES-1:0]             neg;
      logic [MAG_W-1:0]                 m;
      logic                             scaled;
   } div_stage_type;

   div_stage_type stage_ff [DIV_STAGES];
   div_stage_type stage_in [DIV_STAGES];

   always_comb begin
      div_stage_type cur;
      logic [MAG_W:0] trial;
      logic           ge;
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (s == 0) begin
            cur.mag    = div_in.mag;
            cur.neg    = div_in.neg;
            cur.m      = div_in.m;
            cur.scaled = div_in.scaled;
            for (int l = 0; l < NUM_LANES; l++) begin
               cur.rem[l] = div_in.num[l][NUM_W-1:Q_BITS];
               cur.nlo[l] = div_in.num[l][Q_BITS-1:0];
            end
         end else begin
            cur = stage_ff[s-1];
         end
         // restoring steps: shift in the next dividend bit, keep the quotient bit
         for (int b = 0; b < BITS_PER_STAGE; b++) begin
            for (int l = 0; l < NUM_LANES; l++) begin
               trial = {cur.rem[l], cur.nlo[l][Q_BITS-1]};
               ge    = trial >= {1'b0, cur.m};
               if (ge) begin
                  trial = trial - {1'b0, cur.m};
               end
               cur.rem[l] = trial[MAG_W-1:0];
               cur.nlo[l] = {cur.nlo[l][Q_BITS-2:0], ge};
            end
         end
         stage_in[s] = cur;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (en[s]) begin
            stage_ff[s] <= stage_in[s];
         end
      end
   end

   assign div_out.quo    = stage_ff[DIV_STAGES-1].nlo;
   assign div_out.mag    = stage_ff[DIV_STAGES-1].mag;
   assign div_out.neg    = stage_ff[DIV_STAGES-1].neg;
   assign div_out.scaled = stage_ff[DIV_STAGES-1].scaled;

endmodule

[rtl/foc_inverse_park_clarke_pwm_core.sv]
`timescale 1ns / 1ps
// Inverse Park / inverse Clarke voltage modulator with sinusoidal PWM duty
// output. One encoder sample is accepted per cycle while req_ready is high;
// its three duties pass through 8 front stages (angle, table lookup, Park,
// Clarke, peak search and dividend setup), 8 stages of a two-bit-per-stage
// restoring divider for the peak normalization, and an output register.
// Each stage holds its transaction while the next is full, so bubbles are
// squeezed out and input is still taken while a result waits on rsp_ready.
// Registers are written through csr_we/csr_index/csr_wdata and must only
// change while no transaction is in flight.
module foc_inverse_park_clarke_pwm_core
   import foc_ipcp_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [ENCODER_BITS-1:0] req_raw_angle,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [15:0]             rsp_duty_a,
   output logic [15:0]             rsp_duty_b,
   output logic [15:0]             rsp_duty_c,
   output logic                    rsp_was_scaled,
   input  logic                    csr_we,
   input  logic [1:0]              csr_index,
   input  logic [15:0]             csr_wdata
);

   localparam int FRONT_STAGES = 8;
   localparam int NS           = FRONT_STAGES + DIV_STAGES + 1;
   localparam logic signed [16:0] CLARKE_K = 17'sd28377;

   // configuration
   logic [5:0]         pole_pairs_ff;
   logic [15:0]        angle_offset_ff;
   logic signed [15:0] volt_d_ff;
   logic signed [15:0] volt_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pole_pairs_ff   <= POLE_PAIRS_RST[5:0];
         angle_offset_ff <= '0;
         volt_d_ff       <= '0;
         volt_q_ff       <= VOLT_Q_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_POLE_PAIRS:   pole_pairs_ff   <= csr_wdata[5:0];
            CSR_ANGLE_OFFSET: angle_offset_ff <= csr_wdata;
            CSR_VOLT_D:       volt_d_ff       <= csr_wdata;
            CSR_VOLT_Q:       volt_q_ff       <= csr_wdata;
         endcase
      end
   end

   // stage valids and per-stage advance
   logic [NS:1] vld_ff;
   logic [NS:1] en;

   always_comb begin
      en[NS] = ~vld_ff[NS] | rsp_ready;
      for (int i = NS - 1; i >= 1; i--) begin
         en[i] = ~vld_ff[i] | en[i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[1]) begin
            vld_ff[1] <= req_valid;
         end
         for (int i = 2; i <= NS; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   assign req_ready = en[1];
   assign rsp_valid = vld_ff[NS];

   // stage 1: electrical angle
   logic [15:0]                turn16;
   logic [21:0]                el_prod;
   logic [15:0]                el;
   logic [SINE_TABLE_BITS-1:0] idx_ff;

   assign turn16  = {req_raw_angle, {(16 - ENCODER_BITS){1'b0}}};
   assign el_prod = turn16 * pole_pairs_ff;
   assign el      = el_prod[15:0] - angle_offset_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         idx_ff <= el[15 -: SINE_TABLE_BITS];
      end
   end

   // stage 2: sine and cosine
   logic signed [15:0] sn_ff, cs_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         sn_ff <= sine_lookup(idx_ff);
         cs_ff <= sine_lookup(idx_ff + SINE_TABLE_BITS'(QTR_DEPTH));
      end
   end

   // stage 3: Park products
   logic signed [31:0] dc_ff, qs_ff, ds_ff, qc_ff;

   always_ff @(posedge clock) begin
      if (en[3]) begin
         dc_ff <= volt_d_ff * cs_ff;
         qs_ff <= volt_q_ff * sn_ff;
         ds_ff <= volt_d_ff * sn_ff;
         qc_ff <= volt_q_ff * cs_ff;
      end
   end

   // stage 4: alpha, beta with round half up
   logic signed [32:0] sum_alpha, sum_beta;
   logic signed [17:0] alpha_ff, beta_ff;

   assign sum_alpha = 33'(dc_ff) - 33'(qs_ff) + 33'sd16384;
   assign sum_beta  = 33'(ds_ff) + 33'(qc_ff) + 33'sd16384;

   always_ff @(posedge clock) begin
      if (en[4]) begin
         alpha_ff <= 18'(sum_alpha >>> 15);
         beta_ff  <= 18'(sum_beta >>> 15);
      end
   end

   // stage 5: Clarke products
   logic signed [34:0] ha_ff, kb_ff;
   logic signed [17:0] alpha5_ff;

   always_ff @(posedge clock) begin
      if (en[5]) begin
         ha_ff     <= 35'(alpha_ff) <<< 14;
         kb_ff     <= beta_ff * CLARKE_K;
         alpha5_ff <= alpha_ff;
      end
   end

   // stage 6: phases
   logic signed [35:0] sum_b, sum_c;
   logic signed [18:0] ph_ff [NUM_LANES];

   assign sum_b = 36'(kb_ff) - 36'(ha_ff) + 36'sd16384;
   assign sum_c = -36'(kb_ff) - 36'(ha_ff) + 36'sd16384;

   always_ff @(posedge clock) begin
      if (en[6]) begin
         ph_ff[0] <= 19'(alpha5_ff);
         ph_ff[1] <= 19'(sum_b >>> 15);
         ph_ff[2] <= 19'(sum_c >>> 15);
      end
   end

   // stage 7: magnitudes and peak
   logic [NUM_LANES-1:0][MAG_W-1:0] mag_in, mag_ff;
   logic [NUM_LANES-1:0]            neg_ff;
   logic [MAG_W-1:0]                peak_in, peak_ff;
   logic                            scaled_ff;

   always_comb begin
      logic [18:0] a;
      for (int l = 0; l < NUM_LANES; l++) begin
         a         = ph_ff[l][18] ? 19'(-ph_ff[l]) : ph_ff[l];
         mag_in[l] = a[MAG_W-1:0];
      end
      peak_in = mag_in[0];
      if (mag_in[1] > peak_in) begin
         peak_in = mag_in[1];
      end
      if (mag_in[2] > peak_in) begin
         peak_in = mag_in[2];
      end
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         mag_ff    <= mag_in;
         peak_ff   <= peak_in;
         scaled_ff <= peak_in > Q15_ONE;
         for (int l = 0; l < NUM_LANES; l++) begin
            neg_ff[l] <= ph_ff[l][18];
         end
      end
   end

   // stage 8: dividends |v|*32768 + peak/2
   div_in_type  div_in_ff;
   div_out_type div_out;

   always_ff @(posedge clock) begin
      if (en[8]) begin
         for (int l = 0; l < NUM_LANES; l++) begin
            div_in_ff.num[l] <= {mag_ff[l], 15'd0} + NUM_W'(peak_ff >> 1);
         end
         div_in_ff.mag    <= mag_ff;
         div_in_ff.neg    <= neg_ff;
         div_in_ff.m      <= peak_ff;
         div_in_ff.scaled <= scaled_ff;
      end
   end

   foc_ipcp_divider u_divider (
      .clock   (clock),
      .en      (en[FRONT_STAGES + DIV_STAGES : FRONT_STAGES + 1]),
      .div_in  (div_in_ff),
      .div_out (div_out)
   );

   // output stage: duty = 32768 + v, saturated
   logic [NUM_LANES-1:0][15:0] duty_in;
   logic [NUM_LANES-1:0][15:0] duty_ff;
   logic                       was_scaled_ff;

   always_comb begin
      logic [15:0] val;
      for (int l = 0; l < NUM_LANES; l++) begin
         val = div_out.scaled ? div_out.quo[l] : div_out.mag[l][15:0];
         if (div_out.neg[l]) begin
            duty_in[l] = 16'(17'd32768 - {1'b0, val});
         end else if (val[15]) begin
            duty_in[l] = 16'hFFFF;
         end else begin
            duty_in[l] = 16'(17'd32768 + {1'b0, val});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[NS]) begin
         duty_ff       <= duty_in;
         was_scaled_ff <= div_out.scaled;
      end
   end

   assign rsp_duty_a     = duty_ff[0];
   assign rsp_duty_b     = duty_ff[1];
   assign rsp_duty_c     = duty_ff[2];
   assign rsp_was_scaled = was_scaled_ff;

endmodule
